FILE: hdl/pmip_pkg.sv
package pmip_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int NumTypesDef  = 16;

  localparam logic signed [31:0] EmptyMark = 32'sh8000_0000;

  // Register indexes
  localparam logic [2:0] RegRowX   = 3'd0;
  localparam logic [2:0] RegRowY   = 3'd1;
  localparam logic [2:0] RegRowW   = 3'd2;
  localparam logic [2:0] RegRatioX = 3'd3;
  localparam logic [2:0] RegRatioY = 3'd4;
  localparam logic [2:0] RegWidth  = 3'd5;
  localparam logic [2:0] RegHeight = 3'd6;
  localparam logic [2:0] RegMask   = 3'd7;

  localparam logic [0:0] ModeSplat = 1'b0;
  localparam logic [0:0] ModeRead  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_PIX,
    ST_ADDR,
    ST_RD,
    ST_WR,
    ST_OUT
  } pmip_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic clr_step;   // one entry of the clearing pass
    logic mul;        // multiply stage
    logic sum;        // sum stage
    logic div_start;  // start the dividers
    logic pix;        // pixel scale stage
    logic addr;       // address and bounds stage
    logic mem_rd;     // memory read
    logic mem_wr;     // write back and form result
  } pmip_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic drop;   // item needs no projection result (inactive or w zero)
    logic is_read;
  } pmip_sts_t;

endpackage

FILE: hdl/pmip_if.sv
interface pmip_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [7:0]         particle_type;
  logic               point_active;
  logic signed [31:0] scalar_value;
  logic [15:0]        read_index;

  modport source (output valid, mode, point_x, point_y, point_z, particle_type,
                  point_active, scalar_value, read_index, input ready);
  modport sink (input valid, mode, point_x, point_y, point_z, particle_type,
                point_active, scalar_value, read_index, output ready);
endinterface

interface pmip_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [15:0]        pixel_index;
  logic signed [31:0] pixel_value;
  logic               pixel_empty;

  modport source (output valid, hit, pixel_index, pixel_value, pixel_empty,
                  input ready);
  modport sink (input valid, hit, pixel_index, pixel_value, pixel_empty,
                output ready);
endinterface

FILE: hdl/point_max_intensity_projection_top.sv
// Maximum-intensity point splatter. One item at a time: a splat runs two
// 80-step radix-2 dividers in parallel, a dropped splat and a read-and-clear
// do not wait on them, and each also waits on out_ready. After reset a
// clearing pass writes the empty marker to all MAX_WIDTH*MAX_HEIGHT entries,
// one per cycle, before the first item is taken.
module point_max_intensity_projection_top
  import pmip_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef,
  parameter int NUM_TYPES  = NumTypesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  pmip_in_if.sink     in_ch,
  pmip_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  pmip_cmd_t cmd;
  pmip_sts_t sts;
  logic      res_hit, res_empty;
  logic [15:0] res_index;
  logic [31:0] res_value;

  pmip_ctrl u_ctrl (
    .clk, .rst_n, .sts, .cmd,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );

  pmip_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .NUM_TYPES(NUM_TYPES)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_ch,
    .cfg_we, .cfg_index, .cfg_data,
    .res_hit, .res_index, .res_value, .res_empty
  );

  assign out_ch.hit         = res_hit;
  assign out_ch.pixel_index = res_index;
  assign out_ch.pixel_value = res_value;
  assign out_ch.pixel_empty = res_empty;

endmodule

FILE: hdl/pmip_div.sv
// Radix-2 restoring divider: signed 64 / 64, 38-bit quotient magnitude,
// saturated to 2^37. Numerator is pre-shifted by 16 bits (Q.16 result).
module pmip_div
  import pmip_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [38:0] quo
);

  localparam int QBits = 38;

  logic [79:0]  a_r, a_nxt;     // |num| << 16
  logic [63:0]  b_r, b_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [QBits-1:0] q_r, q_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         neg_r, neg_nxt;
  logic         sat_r, sat_nxt;
  logic [64:0]  trial;
  logic [37:0]  mag;
  logic [63:0]  abs_n, abs_d;

  assign abs_n = num[63] ? 64'(-num) : 64'(num);
  assign abs_d = den[63] ? 64'(-den) : 64'(den);
  assign trial = {rem_r, a_r[79]} - {1'b0, b_r};

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; rem_nxt = rem_r; q_nxt = q_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; neg_nxt = neg_r; sat_nxt = sat_r;
    if (start) begin
      a_nxt = {abs_n, 16'd0};
      b_nxt = abs_d;
      rem_nxt = '0; q_nxt = '0; cnt_nxt = 7'd80; busy_nxt = 1'b1; sat_nxt = 1'b0;
      neg_nxt = num[63] ^ den[63];
    end else if (busy_r) begin
      // one quotient bit per cycle; bits above QBits only flag saturation
      a_nxt = {a_r[78:0], 1'b0};
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        if (cnt_r > 7'(QBits)) sat_nxt = 1'b1;
        q_nxt = {q_r[QBits-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], a_r[79]};
        q_nxt = {q_r[QBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    neg_r <= neg_nxt; sat_r <= sat_nxt;
  end

  assign done = !busy_r;
  assign mag  = (sat_r || q_r > 38'(64'd1 << 37)) ? 38'(64'd1 << 37) : q_r;
  assign quo  = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

FILE: hdl/pmip_datapath.sv
module pmip_datapath
  import pmip_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef,
  parameter int NUM_TYPES  = NumTypesDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pmip_cmd_t       cmd,
  output pmip_sts_t       sts,
  pmip_in_if.sink         in_ch,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  output logic            res_hit,
  output logic [15:0]     res_index,
  output logic [31:0]     res_value,
  output logic            res_empty
);

  localparam int Store = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (Store > 1) ? $clog2(Store) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  // Configuration registers
  logic [63:0] row_x_r, row_y_r, row_w_r;
  logic [23:0] ratio_x_r, ratio_y_r;
  logic [8:0]  width_r, height_r;
  logic [15:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= '0; row_y_r <= '0; row_w_r <= '0;
      ratio_x_r <= 24'd32768; ratio_y_r <= 24'd32768;
      width_r <= 9'd256; height_r <= 9'd256; mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRowX:   row_x_r <= cfg_data;
        RegRowY:   row_y_r <= cfg_data;
        RegRowW:   row_w_r <= cfg_data;
        RegRatioX: ratio_x_r <= cfg_data[23:0];
        RegRatioY: ratio_y_r <= cfg_data[23:0];
        RegWidth:  width_r <= cfg_data[8:0];
        RegHeight: height_r <= cfg_data[8:0];
        RegMask:   mask_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic               mode_r, act_r;
  logic signed [31:0] px_r, py_r, pz_r, scal_r;
  logic [15:0]        ridx_r;
  logic [7:0]         typ;

  always_comb begin
    typ = (in_ch.particle_type >= 8'(NUM_TYPES)) ? 8'd0 : in_ch.particle_type;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_ch.mode;
      act_r  <= in_ch.point_active && mask_r[typ[3:0]];
      px_r <= in_ch.point_x; py_r <= in_ch.point_y; pz_r <= in_ch.point_z;
      scal_r <= in_ch.scalar_value;
      ridx_r <= in_ch.read_index;
    end
  end

  // Products: 9 of 16x32, registered
  logic signed [47:0] prod_r [3][3];
  logic signed [63:0] vx_r, vy_r, vw_r;

  function automatic logic signed [15:0] cf(input logic [63:0] row, input int k);
    cf = $signed(row[16*k +: 16]);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= cf(r == 0 ? row_x_r : r == 1 ? row_y_r : row_w_r, 0) * px_r;
        prod_r[r][1] <= cf(r == 0 ? row_x_r : r == 1 ? row_y_r : row_w_r, 1) * py_r;
        prod_r[r][2] <= cf(r == 0 ? row_x_r : r == 1 ? row_y_r : row_w_r, 2) * pz_r;
      end
    end
    if (cmd.sum) begin
      vx_r <= 64'(prod_r[0][0]) + 64'(prod_r[0][1]) + 64'(prod_r[0][2])
              + {{32{row_x_r[63]}}, row_x_r[63:48], 16'd0};
      vy_r <= 64'(prod_r[1][0]) + 64'(prod_r[1][1]) + 64'(prod_r[1][2])
              + {{32{row_y_r[63]}}, row_y_r[63:48], 16'd0};
      vw_r <= 64'(prod_r[2][0]) + 64'(prod_r[2][1]) + 64'(prod_r[2][2])
              + {{32{row_w_r[63]}}, row_w_r[63:48], 16'd0};
    end
  end

  // Dividers
  logic done_x, done_y;
  logic signed [38:0] qx, qy;

  pmip_div u_div_x (.clk, .rst_n, .start(cmd.div_start), .num(vx_r), .den(vw_r),
                    .done(done_x), .quo(qx));
  pmip_div u_div_y (.clk, .rst_n, .start(cmd.div_start), .num(vy_r), .den(vw_r),
                    .done(done_y), .quo(qy));

  // Pixel scale: (pos + 1.0) * ratio + 0.5, truncate toward zero
  logic signed [64:0] sx_r, sy_r;

  function automatic logic signed [39:0] trunc24(input logic signed [64:0] s);
    logic [64:0] m;
    m = s[64] ? 65'(-s) : 65'(s);
    trunc24 = s[64] ? -$signed(40'(m >> 24)) : $signed(40'(m >> 24));
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.pix) begin
      sx_r <= (65'(qx) + 65'sd65536) * $signed({1'b0, ratio_x_r}) + 65'sd8388608;
      sy_r <= (65'(qy) + 65'sd65536) * $signed({1'b0, ratio_y_r}) + 65'sd8388608;
    end
  end

  // Address and bounds
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          in_img_r;
  logic [AW-1:0] addr_r;
  logic [39:0]   ixc, iyc;

  assign w_eff = (32'(width_r) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_r);
  assign h_eff = (32'(height_r) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_r);
  assign ixc = trunc24(sx_r);
  assign iyc = trunc24(sy_r);

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      in_img_r <= !ixc[39] && !iyc[39] && (ixc < 40'(w_eff)) && (iyc < 40'(h_eff));
      addr_r <= mode_r ? AW'(ridx_r) : AW'(ixc[23:0] + iyc[23:0] * 24'(w_eff));
    end
  end

  // Image store with clearing pass
  logic signed [31:0] mem [Store];
  logic signed [31:0] rd_r;
  logic [AW:0]        clr_r;
  logic               ridx_ok;

  assign ridx_ok = 32'(ridx_r) < 32'(Store);

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_r <= mem[addr_r];
    if (cmd.clr_step) mem[clr_r[AW-1:0]] <= EmptyMark;
    else if (cmd.mem_wr) begin
      if (mode_r) begin
        if (ridx_ok) mem[addr_r] <= EmptyMark;
      end else if (act_r && vw_r != 0 && in_img_r && scal_r > rd_r) begin
        mem[addr_r] <= scal_r;
      end
    end
  end

  // Result
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      if (mode_r) begin
        res_hit   <= 1'b0;
        res_index <= ridx_r;
        res_value <= ridx_ok ? rd_r : EmptyMark;
        res_empty <= !ridx_ok || rd_r == EmptyMark;
      end else if (act_r && vw_r != 0 && in_img_r) begin
        res_hit   <= 1'b1;
        res_index <= 16'(addr_r);
        res_value <= (scal_r > rd_r) ? scal_r : rd_r;
        res_empty <= 1'b0;
      end else begin
        res_hit <= 1'b0; res_index <= '0; res_value <= '0; res_empty <= 1'b0;
      end
    end
  end

  assign sts.clr_done = clr_r[AW-1:0] == AW'(Store - 1) || clr_r[AW];
  assign sts.div_done = done_x && done_y;
  assign sts.drop     = !act_r || vw_r == 0;
  assign sts.is_read  = mode_r;

endmodule

FILE: hdl/pmip_ctrl.sv
module pmip_ctrl
  import pmip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pmip_sts_t sts,
  output pmip_cmd_t cmd,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready
);

  pmip_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = sts.is_read ? ST_ADDR : ST_SUM;
      ST_SUM:   state_nxt = ST_DIV;
      ST_DIV:   if (sts.drop) state_nxt = ST_WR;
                else if (sts.div_done) state_nxt = ST_PIX;
      ST_PIX:   state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_WR;
      ST_WR:    state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  logic div_go_r;
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE:  begin in_ready = 1'b1; cmd.load = in_valid; end
      ST_MUL:   cmd.mul = 1'b1;
      ST_SUM:   cmd.sum = 1'b1;
      ST_DIV:   cmd.div_start = !div_go_r;
      ST_PIX:   cmd.pix = 1'b1;
      ST_ADDR:  cmd.addr = 1'b1;
      ST_RD:    cmd.mem_rd = 1'b1;
      ST_WR:    cmd.mem_wr = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  // Hold off division done until the dividers have started
  logic div_wait_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; div_go_r <= 1'b0; div_wait_r <= 1'b0;
    end else begin
      div_go_r <= (state_r == ST_DIV);
      div_wait_r <= cmd.div_start;
      state_r <= (state_r == ST_DIV && (cmd.div_start || div_wait_r) && !sts.drop)
                 ? ST_DIV : state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |=> out_valid) else $error("result not presented");

endmodule
